// ===== sv/cdq_pkg.sv =====
// shared constants, codes and types for the circular deque
package cdq_pkg;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;

  localparam logic [CNT_BITS-1:0] CAPACITY_RESET = CNT_BITS'(20);

  // register index, taken from the word address
  localparam logic [ADDR_BITS-3:0] REG_CAPACITY = '0;

  typedef enum logic [1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_POP_HEAD  = 2'd1,
    OP_PUSH_TAIL = 2'd2,
    OP_POP_TAIL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                 shift_right;
    logic                 shift_left;
    logic                 load_tail;
    logic [IDX_BITS-1:0]  tail_slot;
    logic [IDX_BITS-1:0]  read_slot;
    logic [WORD_BITS-1:0] push_word;
  } cdq_cmd_t;

endpackage

// ===== sv/circular_deque.sv =====
// circular deque top level: control, count, config register and cell chain
//
//   channel   direction  signals                                  transfer when
//   input     in         in_valid_i/in_ready_o, operation_i,      in_valid_i & in_ready_o
//                        push_word_i
//   result    out        out_valid_o/out_ready_i, pop_word_o,     out_valid_o & out_ready_i
//                        status_o, occupancy_o
//   config    in         psel, penable, pwrite, paddr, pwdata,    psel & penable & pwrite
//                        prdata, pready
//
// one operation per cycle while the result side keeps up: the result is registered at the edge of the input
// transfer, and the whole word chain shifts or loads at that same edge
// the input side stalls only while a result waits and out_ready_i is low
// reset empties the deque and sets capacity to 20; no clearing pass is needed
// a capacity write empties the deque, words left in the cells become unreachable
module circular_deque (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           operation_i,
  input  logic signed [cdq_pkg::WORD_BITS-1:0] push_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [cdq_pkg::WORD_BITS-1:0] pop_word_o,
  output logic [1:0]                           status_o,
  output logic [cdq_pkg::CNT_BITS-1:0]         occupancy_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cdq_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [cdq_pkg::DATA_BITS-1:0]        pwdata,
  output logic [cdq_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);
  import cdq_pkg::*;

  // words are kept in order: cell 0 holds the head, cell held-1 the tail
  logic [CNT_BITS-1:0]  held_q, held_d;
  logic [CNT_BITS-1:0]  cap_q;
  logic [CNT_BITS-1:0]  cap_eff;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] pop_word_q;
  status_e              status_q, status_d;
  logic [CNT_BITS-1:0]  occ_q;

  logic      accept;
  logic      cap_wr;
  logic      is_push;
  logic      full;
  logic      empty;
  logic      op_ok;
  op_e       op;
  cdq_cmd_t  cmd;

  logic [WORD_BITS-1:0] cell_word [DEPTH];
  logic [WORD_BITS-1:0] cell_tap  [DEPTH];
  logic [WORD_BITS-1:0] tap_word;

  // config port
  assign pready = 1'b1;
  assign cap_wr = psel && penable && pwrite && (paddr[ADDR_BITS-1:2] == REG_CAPACITY);

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_BITS-1:2] == REG_CAPACITY) begin
      prdata = DATA_BITS'(cap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else if (cap_wr) begin
      cap_q <= pwdata[CNT_BITS-1:0];
    end
  end

  // zero counts as one slot, anything past the built depth saturates
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_BITS'(1);
    end else if (cap_q > CNT_BITS'(DEPTH)) begin
      cap_eff = CNT_BITS'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  // handshake: take a new item whenever the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign op      = op_e'(operation_i);
  assign is_push = (op == OP_PUSH_HEAD) || (op == OP_PUSH_TAIL);
  assign full    = (held_q >= cap_eff);
  assign empty   = (held_q == '0);
  assign op_ok   = is_push ? !full : !empty;

  always_comb begin
    status_d = ST_OK;
    if (is_push && full) begin
      status_d = ST_FULL;
    end else if (!is_push && empty) begin
      status_d = ST_EMPTY;
    end
  end

  // command to the chain, gated by a successful transfer
  always_comb begin
    cmd             = '0;
    cmd.push_word   = WORD_BITS'(push_word_i);
    cmd.tail_slot   = held_q[IDX_BITS-1:0];
    cmd.read_slot   = '0;
    case (op)
      OP_PUSH_HEAD: cmd.shift_right = accept && op_ok;
      OP_POP_HEAD:  cmd.shift_left  = accept && op_ok;
      OP_PUSH_TAIL: cmd.load_tail   = accept && op_ok;
      OP_POP_TAIL:  cmd.read_slot   = IDX_BITS'(held_q - CNT_BITS'(1));
      default:      cmd.read_slot   = '0;
    endcase
  end

  // count
  always_comb begin
    held_d = held_q;
    if (cap_wr) begin
      held_d = '0;
    end else if (accept && op_ok) begin
      held_d = is_push ? held_q + CNT_BITS'(1) : held_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  // the cell chain; cell 0 takes the pushed word on a head push
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_word;
    logic [WORD_BITS-1:0] right_word;

    if (g == 0) begin : g_first
      assign left_word = WORD_BITS'(push_word_i);
    end else begin : g_mid_left
      assign left_word = cell_word[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_word = cell_word[g];
    end else begin : g_mid_right
      assign right_word = cell_word[g+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (IDX_BITS'(g)),
      .cmd_i        (cmd),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .word_o       (cell_word[g]),
      .tap_o        (cell_tap[g])
    );
  end

  // only the addressed cell drives its tap, so an or over the row picks it
  always_comb begin
    tap_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_word = tap_word | cell_tap[i];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_word_q <= (!is_push && op_ok) ? tap_word : '0;
      status_q   <= status_d;
      occ_q      <= held_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pop_word_o  = $signed(pop_word_q);
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

endmodule

// ===== sv/cdq_cell.sv =====
// one storage cell of the deque chain
module cdq_cell (
  input  logic                          clk_i,
  input  logic [cdq_pkg::IDX_BITS-1:0]  cell_idx_i,
  input  cdq_pkg::cdq_cmd_t             cmd_i,
  input  logic [cdq_pkg::WORD_BITS-1:0] left_word_i,
  input  logic [cdq_pkg::WORD_BITS-1:0] right_word_i,
  output logic [cdq_pkg::WORD_BITS-1:0] word_o,
  output logic [cdq_pkg::WORD_BITS-1:0] tap_o
);
  import cdq_pkg::*;

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (cmd_i.shift_right) begin
      word_d = left_word_i;
    end else if (cmd_i.shift_left) begin
      word_d = right_word_i;
    end else if (cmd_i.load_tail && (cell_idx_i == cmd_i.tail_slot)) begin
      word_d = cmd_i.push_word;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign tap_o  = (cell_idx_i == cmd_i.read_slot) ? word_q : '0;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the circular deque: random traffic, live prediction and apb setup
`timescale 1ns / 100ps

module tb;
  import cdq_pkg::*;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0] count_t;

  typedef struct {
    op_e   op;
    word_t word;
  } deque_op_t;

  typedef struct {
    word_t   pop_word;
    status_e status;
    count_t  occupancy;
  } deque_result_t;

  // receiver behavior while no hold-off is running
  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  localparam logic [ADDR_BITS-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam int unsigned ITEMS_PER_PHASE  = 112;
  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned NUM_CAP_SETTINGS = 11;

  // capacity values written one phase after another; raw bus words, so the
  // upper bits get exercised and the zero / oversize cases are hit
  localparam logic [DATA_BITS-1:0] CAP_SETTINGS [NUM_CAP_SETTINGS] = '{
    32'd32, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd40, 32'd5, 32'h0000_0111,
    32'd31, 32'd3, 32'd20
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           op_drv = '0;
  word_t                word_drv = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  word_t                pop_word_o;
  logic [1:0]           status_o;
  count_t               occupancy_o;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  circular_deque dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .operation_i (op_drv),
    .push_word_i (word_drv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .pop_word_o  (pop_word_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // operations waiting to be offered, and results predicted but not yet seen
  deque_op_t     queued_ops[$];
  deque_result_t predicted_results[$];
  int unsigned   error_count = 0;

  // shadow copy of the deque contents and the capacity register
  word_t               shadow_slots [DEPTH];
  count_t              shadow_front;
  count_t              shadow_back;
  count_t              shadow_held;
  logic [CNT_BITS-1:0] shadow_cap_reg;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // applies one operation to the shadow deque and returns what the block must answer
  function automatic deque_result_t predict_deque_op(input op_e op, input word_t word);
    deque_result_t res;
    count_t        cap;
    cap = (shadow_cap_reg == '0) ? count_t'(1) :
          (shadow_cap_reg > count_t'(DEPTH)) ? count_t'(DEPTH) : shadow_cap_reg;
    if (shadow_front >= cap) shadow_front = '0;
    if (shadow_back >= cap) shadow_back = '0;
    res.pop_word = '0;
    res.status   = ST_OK;
    case (op)
      OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (shadow_held >= cap) begin
          // full: the word is dropped
          res.status = ST_FULL;
        end else if (op == OP_PUSH_HEAD) begin
          shadow_front = (shadow_front == '0) ? cap - 1'b1 : shadow_front - 1'b1;
          shadow_slots[shadow_front[IDX_BITS-1:0]] = word;
          shadow_held++;
        end else begin
          shadow_slots[shadow_back[IDX_BITS-1:0]] = word;
          shadow_back = (shadow_back + 1'b1 >= cap) ? '0 : shadow_back + 1'b1;
          shadow_held++;
        end
      end
      default: begin
        if (shadow_held == '0) begin
          res.status = ST_EMPTY;
        end else if (op == OP_POP_HEAD) begin
          res.pop_word = shadow_slots[shadow_front[IDX_BITS-1:0]];
          shadow_front = (shadow_front + 1'b1 >= cap) ? '0 : shadow_front + 1'b1;
          shadow_held--;
        end else begin
          shadow_back = (shadow_back == '0) ? cap - 1'b1 : shadow_back - 1'b1;
          res.pop_word = shadow_slots[shadow_back[IDX_BITS-1:0]];
          shadow_held--;
        end
      end
    endcase
    res.occupancy = shadow_held;
    return res;
  endfunction

  function automatic void queue_op(input op_e op, input word_t word);
    deque_op_t item;
    item.op   = op;
    item.word = word;
    queued_ops.push_back(item);
  endfunction

  // random traffic in chunks, each chunk leaning toward pushes, toward pops or balanced, so the
  // deque swings between empty and full and the indices wrap
  function automatic void queue_random_ops(input int unsigned count);
    int unsigned added;
    int unsigned chunk;
    int unsigned push_pct;
    word_t       word;
    op_e         op;
    added = 0;
    while (added < count) begin
      chunk = $urandom_range(10, 50);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      for (int unsigned i = 0; i < chunk && added < count; i++) begin
        case ($urandom_range(0, 9))
          0:       word = {1'b0, {(WORD_BITS-1){1'b1}}};
          1:       word = {1'b1, {(WORD_BITS-1){1'b0}}};
          2:       word = '0;
          3:       word = '1;
          default: word = word_t'($urandom);
        endcase
        if ($urandom_range(1, 100) <= push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        else
          op = $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL;
        queue_op(op, word);
        added++;
      end
    end
  endfunction

  // one apb transfer: setup cycle, access cycle, pready is tied high
  task automatic apb_access(input bit wr, input logic [DATA_BITS-1:0] wdata,
                            output logic [DATA_BITS-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    // register takes the write at this edge
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // waits until every offered operation is through and every result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_ops.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // sequencer: reset, directed traffic, then one random phase per capacity
  // ---------------------------------------------------------------------------
  initial begin
    logic [DATA_BITS-1:0] rdata;
    logic [DATA_BITS-1:0] readback_exp;

    for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;
    shadow_front   = '0;
    shadow_back    = '0;
    shadow_held    = '0;
    shadow_cap_reg = CAPACITY_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apb_access(1'b0, '0, rdata);
    if (rdata !== DATA_BITS'(CAPACITY_RESET))
      report_mismatch($sformatf("capacity after reset reads %0d", rdata));
    @(negedge clk_i);

    // empty pops at both ends, extremes pushed at both ends, then drained
    queue_op(OP_POP_HEAD, '0);
    queue_op(OP_POP_TAIL, '1);
    queue_op(OP_PUSH_HEAD, {1'b0, {(WORD_BITS-1){1'b1}}});
    queue_op(OP_PUSH_TAIL, {1'b1, {(WORD_BITS-1){1'b0}}});
    queue_op(OP_PUSH_HEAD, '0);
    queue_op(OP_PUSH_TAIL, '1);
    queue_op(OP_POP_HEAD, '0);
    queue_op(OP_POP_TAIL, '0);
    queue_op(OP_POP_TAIL, '0);
    queue_op(OP_POP_HEAD, '0);
    queue_op(OP_POP_HEAD, '0);
    queue_random_ops(ITEMS_PER_PHASE);
    wait_drained();

    for (int p = 0; p < NUM_CAP_SETTINGS; p++) begin
      apb_access(1'b1, CAP_SETTINGS[p], rdata);
      // a capacity write empties the deque
      shadow_cap_reg = CAP_SETTINGS[p][CNT_BITS-1:0];
      shadow_front   = '0;
      shadow_back    = '0;
      shadow_held    = '0;
      apb_access(1'b0, '0, rdata);
      readback_exp = DATA_BITS'(shadow_cap_reg);
      if (rdata !== readback_exp)
        report_mismatch($sformatf("capacity reads %0d, wrote %0d", rdata, readback_exp));
      @(negedge clk_i);

      // single slot: pushes to a full deque at both ends, empty pops after
      if (CAP_SETTINGS[p] == 32'd1) begin
        queue_op(OP_PUSH_TAIL, 32'h5555_5555);
        queue_op(OP_PUSH_HEAD, 32'h1234_5678);
        queue_op(OP_PUSH_TAIL, 32'h1234_5678);
        queue_op(OP_POP_HEAD, '0);
        queue_op(OP_PUSH_HEAD, 32'hAAAA_AAAA);
        queue_op(OP_POP_TAIL, '0);
        queue_op(OP_POP_TAIL, '0);
      end
      queue_random_ops(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (predicted_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: offers queued operations in bursts separated by random gaps; the
  // prediction is made at the edge where the input transfer happens
  // ---------------------------------------------------------------------------
  deque_op_t   next_op;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o)
        predicted_results.push_back(predict_deque_op(op_e'(op_drv), word_drv));

      // payload may only change once the current one is taken
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_ops.size() != 0) begin
          next_op = queued_ops.pop_front();
          in_valid <= 1'b1;
          op_drv   <= next_op.op;
          word_drv <= next_op.word;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 64);
            case ($urandom_range(0, 19))
              0:       gap_left = 0;
              1, 2, 3: gap_left = $urandom_range(5, 20);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: switches between stall patterns, and twice holds off for a long
  // stretch while plenty of traffic is queued so the input side backs up
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_mode_left = 0;
  int unsigned rx_transfers = 0;
  int unsigned rx_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned next_hold_at = 250;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycles++;
      if (out_valid_o && out_ready) rx_transfers++;

      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_done < 2 && rx_transfers >= next_hold_at &&
                   queued_ops.size() > 40) begin
        hold_left = HOLD_OFF_CYCLES;
        holds_done++;
        next_hold_at = 800;
        out_ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        case (rx_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (rx_cycles % 5 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each result transfer is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  deque_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: word %0d status %0d count %0d",
                                  pop_word_o, status_o, occupancy_o));
      end else begin
        want = predicted_results.pop_front();
        if (pop_word_o !== want.pop_word)
          report_mismatch($sformatf("pop_word %0d, expected %0d", pop_word_o, want.pop_word));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %s", status_o, want.status.name()));
        if (occupancy_o !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d",
                                    occupancy_o, want.occupancy));
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

endmodule
